// File: src/wrmd_pkg.sv
// Constants and field widths shared by the weighted-return maximum drawdown block.
`default_nettype none
package wrmd_pkg;

    localparam int NUM_ASSETS = 16;

    localparam int IDX_W    = 4;
    localparam int SAMPLE_W = 32;
    localparam int VAL_W    = 48;
    localparam int DD_W     = 33;

    localparam int IN_TDATA_W  = 40;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 88;
    localparam int OUT_PAD_W   = OUT_TDATA_W - VAL_W - DD_W;

    localparam int DIV_STEPS = 33;

    localparam logic [VAL_W-1:0] ONE_Q32 = 48'h0001_0000_0000;
    localparam logic [DD_W-1:0]  DD_ONE  = 33'h1_0000_0000;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_RETURN = 1'b1;

endpackage
`default_nettype wire

// File: src/weighted_return_max_drawdown.sv
// Weighted-return maximum drawdown tracker with a shared multiplier and serial divider.
//
//  channel   dir  handshake                       payload
//  s_axis    in   s_axis_tvalid / s_axis_tready   tdata: asset_index, sample_value;
//                                                 tuser: cmd, last_day; tlast: last_in_day
//  m_axis    out  m_axis_tvalid / m_axis_tready   tdata: max_drawdown, final_value
//
//  A weight load is written without leaving S_IDLE; a return that does not end a day
//  passes S_MAC and S_ACC. A day end runs four partial products through the one 33x33
//  multiplier (skipped when the value floors to zero), then a 33-step restoring divider.
//  Reset is synchronous, active low; weights are undefined until loaded.
//  A series end waits in place while the previous result is still held on m_axis.
`default_nettype none
module weighted_return_max_drawdown
    import wrmd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // asset_index[3:0], sample_value[35:4], zeros[39:36]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // cmd[0], last_day[1]
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // max_drawdown[32:0], final_value[80:33], zeros[87:81]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    typedef enum logic [3:0] {
        S_IDLE, S_MAC, S_ACC, S_FAC, S_CMUL, S_CACC, S_CSAT, S_DVSET, S_DIV, S_DONE
    } t_state;

    t_state r_state;

    logic [SAMPLE_W-1:0] r_weights [NUM_ASSETS];
    logic [SAMPLE_W-1:0] r_wt;
    logic [SAMPLE_W-1:0] r_sample;
    logic                r_idx_ok;
    logic                r_last_in_day;
    logic                r_last_day;

    logic [VAL_W-1:0]    r_sum;
    logic [VAL_W-1:0]    r_value;
    logic [VAL_W-1:0]    r_peak;
    logic [DD_W-1:0]     r_worst;
    logic [VAL_W-1:0]    r_fac;
    logic [65:0]         r_prod;
    logic [65:0]         r_acc;
    logic [1:0]          r_k;
    logic [VAL_W:0]      r_rem;
    logic [VAL_W-1:0]    r_den;
    logic [DD_W-1:0]     r_quo;
    logic [5:0]          r_cnt;
    logic                r_out_valid;
    logic [DD_W-1:0]     r_out_dd;
    logic [VAL_W-1:0]    r_out_val;

    logic                w_in_acc;
    logic                w_cmd;
    logic                w_last_day;
    logic [IDX_W-1:0]    w_idx;
    logic [SAMPLE_W-1:0] w_sample;
    logic                w_idx_ok;

    logic signed [32:0]  w_mul_a;
    logic signed [32:0]  w_mul_b;
    logic signed [65:0]  w_mul_p;
    logic [35:0]         w_wret;
    logic [VAL_W:0]      w_sum_ext;
    logic [VAL_W-1:0]    n_sum;
    logic [VAL_W:0]      w_factor;
    logic                w_fac_pos;
    logic [65:0]         w_pp;
    logic [VAL_W-1:0]    w_csat;
    logic [VAL_W-1:0]    w_peak_new;
    logic [VAL_W:0]      w_trial;
    logic                w_ge;
    logic [DD_W-1:0]     w_worst_new;
    logic                w_out_free;
    logic                w_out_load;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid & s_axis_tready;
    assign w_cmd         = s_axis_tuser[0];
    assign w_last_day    = s_axis_tuser[1];
    assign w_idx         = s_axis_tdata[IDX_W-1:0];
    assign w_sample      = s_axis_tdata[IDX_W +: SAMPLE_W];
    assign w_idx_ok      = (32'(w_idx) < NUM_ASSETS);

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            if (w_cmd == CMD_LOAD && w_idx_ok) begin
                r_weights[w_idx] <= w_sample;
            end
            r_wt <= r_weights[w_idx];
        end
    end

    always_comb begin
        w_mul_a = {r_sample[SAMPLE_W-1], r_sample};
        w_mul_b = {r_wt[SAMPLE_W-1], r_wt};
        if (r_state == S_CMUL) begin
            case (r_k)
                2'd0: begin
                    w_mul_a = {1'b0, r_value[31:0]};
                    w_mul_b = {1'b0, r_fac[31:0]};
                end
                2'd1: begin
                    w_mul_a = {17'b0, r_value[47:32]};
                    w_mul_b = {1'b0, r_fac[31:0]};
                end
                2'd2: begin
                    w_mul_a = {1'b0, r_value[31:0]};
                    w_mul_b = {17'b0, r_fac[47:32]};
                end
                default: begin
                    w_mul_a = {17'b0, r_value[47:32]};
                    w_mul_b = {17'b0, r_fac[47:32]};
                end
            endcase
        end
    end

    assign w_mul_p = w_mul_a * w_mul_b;

    assign w_wret    = r_prod[63:28];
    assign w_sum_ext = {r_sum[VAL_W-1], r_sum} + {{13{w_wret[35]}}, w_wret};

    always_comb begin
        n_sum = w_sum_ext[VAL_W-1:0];
        if (w_sum_ext[VAL_W] != w_sum_ext[VAL_W-1]) begin
            n_sum = w_sum_ext[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end
    end

    assign w_factor  = {r_sum[VAL_W-1], r_sum} + {1'b0, ONE_Q32};
    assign w_fac_pos = !w_factor[VAL_W] && (w_factor != '0);

    always_comb begin
        case (r_k)
            2'd0:    w_pp = {34'b0, r_prod[63:32]};
            2'd3:    w_pp = {r_prod[33:0], 32'b0};
            default: w_pp = {2'b0, r_prod[63:0]};
        endcase
    end

    assign w_csat      = (|r_acc[65:VAL_W]) ? '1 : r_acc[VAL_W-1:0];
    assign w_peak_new  = (r_value > r_peak) ? r_value : r_peak;
    assign w_trial     = (r_cnt == '0) ? r_rem : {r_rem[VAL_W-1:0], 1'b0};
    assign w_ge        = (w_trial >= {1'b0, r_den});
    assign w_worst_new = (r_quo > r_worst) ? r_quo : r_worst;
    assign w_out_free  = !r_out_valid || m_axis_tready;
    assign w_out_load  = (r_state == S_DONE) && r_last_day && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_sum       <= '0;
            r_value     <= ONE_Q32;
            r_peak      <= ONE_Q32;
            r_worst     <= '0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_sample      <= w_sample;
                        r_idx_ok      <= w_idx_ok;
                        r_last_in_day <= s_axis_tlast;
                        r_last_day    <= w_last_day;
                        if (w_cmd == CMD_RETURN) begin
                            r_state <= S_MAC;
                        end
                    end
                end
                S_MAC: begin
                    r_prod  <= w_mul_p;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (r_idx_ok) begin
                        r_sum <= n_sum;
                    end
                    r_state <= r_last_in_day ? S_FAC : S_IDLE;
                end
                S_FAC: begin
                    r_sum <= '0;
                    if (w_fac_pos) begin
                        r_fac   <= w_factor[VAL_W-1:0];
                        r_acc   <= '0;
                        r_k     <= '0;
                        r_state <= S_CMUL;
                    end else begin
                        r_value <= '0;
                        r_state <= S_DVSET;
                    end
                end
                S_CMUL: begin
                    r_prod  <= w_mul_p;
                    r_state <= S_CACC;
                end
                S_CACC: begin
                    r_acc   <= r_acc + w_pp;
                    r_k     <= r_k + 2'd1;
                    r_state <= (r_k == 2'd3) ? S_CSAT : S_CMUL;
                end
                S_CSAT: begin
                    r_value <= w_csat;
                    r_state <= S_DVSET;
                end
                S_DVSET: begin
                    r_peak  <= w_peak_new;
                    r_den   <= w_peak_new;
                    r_rem   <= {1'b0, w_peak_new - r_value};
                    r_quo   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem   <= w_ge ? (w_trial - {1'b0, r_den}) : w_trial;
                    r_quo   <= {r_quo[DD_W-2:0], w_ge};
                    r_cnt   <= r_cnt + 6'd1;
                    if (r_cnt == 6'(DIV_STEPS - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_last_day) begin
                        r_worst <= w_worst_new;
                        r_state <= S_IDLE;
                    end else if (w_out_free) begin
                        r_out_dd    <= w_worst_new;
                        r_out_val   <= r_value;
                        r_sum       <= '0;
                        r_value     <= ONE_Q32;
                        r_peak      <= ONE_Q32;
                        r_worst     <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out_val, r_out_dd};

    a_peak_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peak >= ONE_Q32)
        else $error("running peak below 1.0");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem <= {1'b0, r_den}))
        else $error("divider remainder exceeds divisor");

    a_dd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_dd <= DD_ONE))
        else $error("drawdown above 1.0");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result raised outside series end");

endmodule
`default_nettype wire

// File: tb/tb_top.sv
// Testbench for the weighted-return maximum drawdown block: streams weights and returns, checks reports.
`timescale 1ns / 100ps
module tb_top;
    import wrmd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 800;
    localparam int TAIL_CYCLES = 100;
    localparam longint SUM_MAX = 64'sh0000_7fff_ffff_ffff;
    localparam longint SUM_MIN = -SUM_MAX - 1;

    typedef struct packed {
        logic                cmd;
        logic [IDX_W-1:0]    asset;
        logic [SAMPLE_W-1:0] sample;
        logic                day_end;
        logic                series_end;
    } t_feed;

    typedef struct packed {
        logic [DD_W-1:0]  max_dd;
        logic [VAL_W-1:0] final_val;
    } t_report;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // asset_index[3:0], sample_value[35:4], zeros[39:36]
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    // cmd[0], last_day[1]
    logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // max_drawdown[32:0], final_value[80:33], zeros[87:81]
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    t_feed   pending_feed[$];
    t_report expected_reports[$];
    t_feed   next_feed;
    t_feed   seen_feed;
    t_report due_report;

    logic [SAMPLE_W-1:0] weight_mem [NUM_ASSETS];
    logic [NUM_ASSETS-1:0] loaded = '0;
    longint          day_sum;
    logic [VAL_W-1:0] port_val;
    logic [VAL_W-1:0] peak_val;
    logic [DD_W-1:0]  worst_dd;

    int feed_total = 0;
    int fed_cnt = 0;
    int reports_owed = 0;
    int err_cnt = 0;
    int phase_sel = 0;
    int hold_left = HOLD_CYCLES;
    int cycle_cnt = 0;
    logic feed_took = 1'b0;

    weighted_return_max_drawdown dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic queue_load(input int asset, input logic [SAMPLE_W-1:0] w,
                              input logic [1:0] flags);
        t_feed f;
        f.cmd        = CMD_LOAD;
        f.asset      = asset[IDX_W-1:0];
        f.sample     = w;
        f.day_end    = flags[0];
        f.series_end = flags[1];
        pending_feed.push_back(f);
        loaded[asset] = 1'b1;
    endtask

    task automatic queue_return(input int asset, input logic [SAMPLE_W-1:0] r,
                                input logic day_end, input logic series_end);
        t_feed f;
        f.cmd        = CMD_RETURN;
        f.asset      = asset[IDX_W-1:0];
        f.sample     = r;
        f.day_end    = day_end;
        f.series_end = series_end;
        pending_feed.push_back(f);
    endtask

    // mostly small around zero, now and then any 32-bit pattern
    function automatic logic [SAMPLE_W-1:0] rand_q230(input int unsigned span);
        if ($urandom_range(0, 99) < 15)
            return $urandom;
        return $urandom_range(0, 2 * span) - span;
    endfunction

    function automatic int pick_loaded_asset();
        int a;
        do a = $urandom_range(0, NUM_ASSETS - 1); while (!loaded[a]);
        return a;
    endfunction

    function automatic int gap_pct(input bit rx);
        if (phase_sel == 0)
            return rx ? 63 : 24;
        else if (phase_sel == 1)
            return rx ? 24 : 63;
        return 0;
    endfunction

    task automatic restart_series();
        day_sum  = 0;
        port_val = ONE_Q32;
        peak_val = ONE_Q32;
        worst_dd = '0;
    endtask

    task automatic apply_feed(input t_feed f);
        longint prod;
        longint factor;
        logic [95:0] grown;
        logic [80:0] num;
        logic [80:0] den;
        logic [DD_W-1:0] dd;
        t_report rpt;
        if (f.cmd == CMD_LOAD) begin
            weight_mem[f.asset] = f.sample;
        end else begin
            prod = longint'($signed(f.sample)) * longint'($signed(weight_mem[f.asset]));
            day_sum = day_sum + (prod >>> 28);
            if (day_sum > SUM_MAX)
                day_sum = SUM_MAX;
            if (day_sum < SUM_MIN)
                day_sum = SUM_MIN;
            if (f.day_end) begin
                factor = day_sum + longint'(ONE_Q32);
                if (factor <= 0) begin
                    port_val = '0;
                end else begin
                    grown = {48'b0, port_val} * {48'b0, factor[47:0]};
                    grown = grown >> 32;
                    port_val = (grown > 96'hffff_ffff_ffff) ? '1 : grown[VAL_W-1:0];
                end
                day_sum = 0;
                if (port_val > peak_val)
                    peak_val = port_val;
                num = {33'b0, peak_val - port_val} << 32;
                den = {33'b0, peak_val};
                num = num / den;
                dd  = num[DD_W-1:0];
                if (dd > worst_dd)
                    worst_dd = dd;
                if (f.series_end) begin
                    rpt.max_dd    = worst_dd;
                    rpt.final_val = port_val;
                    expected_reports.push_back(rpt);
                    reports_owed++;
                    restart_series();
                end
            end
        end
    endtask

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || feed_took)) begin
            if (pending_feed.size() > 0 && $urandom_range(0, 99) >= gap_pct(1'b0)) begin
                next_feed = pending_feed.pop_front();
                s_axis_tdata  <= {4'b0, next_feed.sample, next_feed.asset};
                s_axis_tuser  <= {next_feed.series_end, next_feed.cmd};
                s_axis_tlast  <= next_feed.day_end;
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= i_rst_n && hold_left == 0 && $urandom_range(0, 99) >= gap_pct(1'b1);
    end

    // hold off the receiver right after reset so results back up
    always @(posedge i_clk) begin
        if (!i_rst_n)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            feed_took <= 1'b0;
            restart_series();
        end else begin
            feed_took <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                seen_feed.cmd        = s_axis_tuser[0];
                seen_feed.series_end = s_axis_tuser[1];
                seen_feed.asset      = s_axis_tdata[IDX_W-1:0];
                seen_feed.sample     = s_axis_tdata[IDX_W +: SAMPLE_W];
                seen_feed.day_end    = s_axis_tlast;
                apply_feed(seen_feed);
                fed_cnt++;
                phase_sel = fed_cnt * 3 / feed_total;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t: unexpected report, expected none, actual dd=%h value=%h",
                             $time, m_axis_tdata[DD_W-1:0], m_axis_tdata[DD_W +: VAL_W]);
                    err_cnt++;
                end else begin
                    due_report = expected_reports.pop_front();
                    reports_owed--;
                    if (m_axis_tdata[DD_W-1:0] !== due_report.max_dd) begin
                        $display("%0t: max_drawdown expected %h actual %h", $time,
                                 due_report.max_dd, m_axis_tdata[DD_W-1:0]);
                        err_cnt++;
                    end
                    if (m_axis_tdata[DD_W +: VAL_W] !== due_report.final_val) begin
                        $display("%0t: final_value expected %h actual %h", $time,
                                 due_report.final_val, m_axis_tdata[DD_W +: VAL_W]);
                        err_cnt++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d of %0d items taken, %0d reports owed",
                     $time, fed_cnt, feed_total, reports_owed);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int days;
        int day_len;
        // weight extremes, flags on loads are ignored
        queue_load(0, 32'h7fff_ffff, 2'b11);
        queue_load(1, 32'h8000_0000, 2'b10);
        queue_load(2, 32'h4000_0000, 2'b01);
        queue_load(3, 32'h0000_0000, 2'b00);
        // last_day alone is an ordinary return; value floors to zero
        queue_return(0, 32'h8000_0000, 1'b0, 1'b1);
        queue_return(3, 32'h7fff_ffff, 1'b1, 1'b1);
        // grow until the value saturates
        repeat (6) queue_return(1, 32'h8000_0000, 1'b1, 1'b0);
        queue_return(1, 32'h8000_0000, 1'b1, 1'b1);
        // rise then fall
        queue_return(2, 32'h2000_0000, 1'b1, 1'b0);
        queue_return(2, 32'he000_0000, 1'b1, 1'b0);
        queue_return(3, 32'h1234_5678, 1'b1, 1'b1);
        // a zero value stays zero
        queue_return(0, 32'h8000_0000, 1'b1, 1'b0);
        queue_return(1, 32'h8000_0000, 1'b1, 1'b1);
        // multi-item day
        queue_return(2, 32'h0000_0001, 1'b0, 1'b0);
        queue_return(0, 32'h7fff_ffff, 1'b0, 1'b0);
        queue_return(1, 32'h7fff_ffff, 1'b1, 1'b1);

        while (pending_feed.size() < 770) begin
            days = $urandom_range(1, 6);
            for (int d = 0; d < days; d++) begin
                day_len = $urandom_range(1, 5);
                for (int i = 0; i < day_len; i++) begin
                    if ($urandom_range(0, 9) == 0)
                        queue_load($urandom_range(0, NUM_ASSETS - 1), rand_q230(32'h1000_0000),
                                   2'($urandom_range(0, 3)));
                    if (i == day_len - 1)
                        queue_return(pick_loaded_asset(), rand_q230(32'h0400_0000), 1'b1,
                                     d == days - 1);
                    else
                        queue_return(pick_loaded_asset(), rand_q230(32'h0400_0000), 1'b0,
                                     $urandom_range(0, 7) == 0);
                end
            end
        end
        feed_total = pending_feed.size();

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (!(fed_cnt == feed_total && reports_owed == 0))
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
